>>> rtl/core/ir_remote_frame_decoder_macros.svh
// Assertion macros shared by the decoder's checker.
`ifndef IR_REMOTE_FRAME_DECODER_MACROS_SVH
`define IR_REMOTE_FRAME_DECODER_MACROS_SVH
`define IRD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/ird_pkg.sv
// Package with types and constants of the IR remote frame decoder.
package ird_pkg;
  localparam int unsigned IvW = 27;
  localparam logic [IvW-1:0] GapKept = 27'd425000;
  typedef logic [IvW-1:0] iv_t;
  typedef enum logic [1:0] {BIT_ZERO = 2'd0, BIT_ONE = 2'd1, BIT_INV = 2'd2} bitcode_t;
  typedef enum logic [1:0] {ST_NONE = 2'd0, ST_KNOWN = 2'd1, ST_UNKNOWN = 2'd2} status_t;
  typedef enum logic [2:0] {
    REG_LEAD_LOW = 3'd0, REG_LEAD_HIGH = 3'd1, REG_GAP_LOW = 3'd2, REG_GAP_HIGH = 3'd3,
    REG_ONE_LOW = 3'd4, REG_ONE_HIGH = 3'd5, REG_ZERO_LOW = 3'd6, REG_ZERO_HIGH = 3'd7
  } reg_idx_t;
  localparam int unsigned CfgIdxW = 4;

  // Returns {known, key} for an address/command pair.
  function automatic logic [5:0] key_of(input logic [3:0] a, input logic [3:0] c);
    logic [5:0] r;
    r = 6'd0;
    if (a == 4'd3) begin
      if (c == 4'd0) r = {1'b1, 5'd9};
      else if (c <= 4'd9) r = {1'b1, 5'(c - 4'd1)};
      else if (c == 4'd15) r = {1'b1, 5'd14};
    end else if (a == 4'd5) begin
      if (c == 4'd6) r = {1'b1, 5'd18};
      else if (c == 4'd7) r = {1'b1, 5'd19};
      else if (c == 4'd9) r = {1'b1, 5'd16};
      else if (c == 4'd8) r = {1'b1, 5'd17};
    end else if (a == 4'd2) begin
      if (c == 4'd15) r = {1'b1, 5'd10};
      else if (c == 4'd14) r = {1'b1, 5'd11};
      else if (c == 4'd13) r = {1'b1, 5'd12};
      else if (c == 4'd12) r = {1'b1, 5'd13};
    end else if (a == 4'd15 && c == 4'd4) begin
      r = {1'b1, 5'd15};
    end
    return r;
  endfunction
endpackage

>>> rtl/core/ir_remote_frame_decoder.sv
// Top level of the IR remote frame decoder: collection, bit decode and frame search.
//  channel | dir | fields
//  in_     | in  | tdata[26:0] edge_interval
//  out_    | out | tdata[1:0] status, [6:2] key_code, [10:7] frame_address,
//          |     | [14:11] frame_command
//  cfg_    | in  | eight 27-bit window bounds
// An interval that does not close a frame leaves the block idle, ready for the next one.
// A closing interval walks the interval memory (S_DRD and S_DCLS per interval, plus
// S_DPRD and S_DMRG when a merge is tried) and then the bit memory (S_SRD and S_SCHK
// per start position) before the result is offered.
// Reset is synchronous; the memories need no clearing.
// A new result waits until the previous one has been transferred; intervals are taken
// only in the idle state, also while a result waits there.
module ir_remote_frame_decoder #(
  parameter int unsigned FRAME_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // edge_interval
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, key_code, frame_address, frame_command
  input  logic        cfg_we,
  input  logic [ird_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [26:0] cfg_wdata
);
  import ird_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned CW = $clog2(FRAME_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DRD, S_DCLS, S_DPRD, S_DMRG, S_SRD, S_SCHK, S_OUT
  } state_t;

  state_t state_r;
  iv_t lead_low_r, lead_high_r, gap_low_r, gap_high_r;
  iv_t one_low_r, one_high_r, zero_low_r, zero_high_r;
  iv_t prev_r;
  logic collecting_r;
  logic [CW-1:0] count_r, size_r, i_r, nbits_r, p_r;
  logic [4:0] j_r;
  iv_t t_r;
  logic [3:0] adr_r, cmd_r, ta_r, tc_r;
  logic ok_r, bad_r;
  logic [1:0] st_r;
  logic [4:0] key_r;
  logic out_valid_r;
  logic [15:0] out_data_r;

  iv_t ivmem [FRAME_DEPTH];
  logic [1:0] bitmem [FRAME_DEPTH];
  iv_t iv_rd_r;
  logic [1:0] bit_rd_r;

  iv_t x;
  logic [IvW:0] sum;
  logic in_lead, x_gap, s_gap, in_acc, close;
  assign x = in_tdata[IvW-1:0];
  assign sum = {1'b0, prev_r} + {1'b0, x};
  assign in_lead = (x > lead_low_r) && (x < lead_high_r);
  assign x_gap = (x > gap_low_r) && (x < gap_high_r);
  assign s_gap = (sum > {1'b0, gap_low_r}) && (sum < {1'b0, gap_high_r});
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  logic full;
  assign full = (count_r == CW'(FRAME_DEPTH));
  assign close = full || x_gap || s_gap;
  logic coll_n;
  assign coll_n = collecting_r || ((prev_r != GapKept) && (in_lead || s_gap));

  // A merge partner past the last counted interval counts as zero.
  iv_t mate;
  assign mate = (i_r < size_r) ? iv_rd_r : '0;
  logic [IvW:0] ts, ms;
  assign ts = {1'b0, iv_rd_r};
  assign ms = {1'b0, t_r} + {1'b0, mate};
  function automatic logic win(input logic [IvW:0] v, input iv_t lo, input iv_t hi);
    return (v > {1'b0, lo}) && (v < {1'b0, hi});
  endfunction

  logic [CW:0] pos;
  assign pos = {1'b0, p_r} + {1'b0, i_r};
  logic pos_in;
  assign pos_in = pos < {1'b0, nbits_r};
  logic [1:0] bval;
  assign bval = pos_in ? bit_rd_r : BIT_INV;

  logic [5:0] kq;
  assign kq = key_of(ta_r, tc_r);

  logic iv_we;
  logic [AW-1:0] iv_wa;
  assign iv_we = in_acc && !full;
  assign iv_wa = count_r[AW-1:0];
  logic [AW-1:0] iv_ra;
  assign iv_ra = i_r[AW-1:0];
  logic bit_we;
  logic [1:0] bit_wd;
  logic [AW-1:0] bit_wa, bit_ra;
  assign bit_wa = nbits_r[AW-1:0];
  assign bit_ra = pos[AW-1:0];

  always_comb begin
    bit_we = 1'b0;
    bit_wd = BIT_INV;
    if (state_r == S_DCLS) begin
      if (win(ts, one_low_r, one_high_r)) begin
        bit_we = 1'b1; bit_wd = BIT_ONE;
      end else if (win(ts, zero_low_r, zero_high_r)) begin
        bit_we = 1'b1; bit_wd = BIT_ZERO;
      end
    end else if (state_r == S_DMRG) begin
      bit_we = 1'b1;
      if (win(ms, one_low_r, one_high_r)) bit_wd = BIT_ONE;
      else if (win(ms, zero_low_r, zero_high_r)) bit_wd = BIT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (iv_we) ivmem[iv_wa] <= x;
    iv_rd_r <= ivmem[iv_ra];
    if (bit_we) bitmem[bit_wa] <= bit_wd;
    bit_rd_r <= bitmem[bit_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lead_low_r <= 27'd400000; lead_high_r <= 27'd410000;
      gap_low_r <= 27'd420000; gap_high_r <= 27'd430000;
      one_low_r <= 27'd123000; one_high_r <= 27'd127000;
      zero_low_r <= 27'd73000; zero_high_r <= 27'd77000;
      prev_r <= '0; collecting_r <= 1'b0; count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index[CfgIdxW-1] == 1'b0) begin
        unique case (reg_idx_t'(cfg_index[2:0]))
          REG_LEAD_LOW: lead_low_r <= cfg_wdata;
          REG_LEAD_HIGH: lead_high_r <= cfg_wdata;
          REG_GAP_LOW: gap_low_r <= cfg_wdata;
          REG_GAP_HIGH: gap_high_r <= cfg_wdata;
          REG_ONE_LOW: one_low_r <= cfg_wdata;
          REG_ONE_HIGH: one_high_r <= cfg_wdata;
          REG_ZERO_LOW: zero_low_r <= cfg_wdata;
          REG_ZERO_HIGH: zero_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_r <= (x_gap || s_gap) ? GapKept : x;
            if (close) begin
              size_r <= (coll_n && !full) ? count_r + 1'b1 : count_r;
              collecting_r <= 1'b0; count_r <= '0;
              i_r <= '0; nbits_r <= '0;
              st_r <= ST_NONE; key_r <= '0; adr_r <= '0; cmd_r <= '0;
              state_r <= S_DRD;
            end else begin
              collecting_r <= coll_n;
              if (coll_n) count_r <= count_r + 1'b1;
            end
          end
        end
        S_DRD: begin
          if (i_r >= size_r) begin
            i_r <= '0; state_r <= S_SRD;
          end else state_r <= S_DCLS;
        end
        S_DCLS: begin
          t_r <= iv_rd_r;
          if (bit_we) begin
            nbits_r <= nbits_r + 1'b1; i_r <= i_r + 1'b1; state_r <= S_DRD;
          end else begin
            i_r <= i_r + 1'b1; state_r <= S_DPRD;
          end
        end
        S_DPRD: begin
          state_r <= S_DMRG;
        end
        S_DMRG: begin
          nbits_r <= nbits_r + 1'b1;
          if (i_r < size_r && bit_wd != BIT_INV) i_r <= i_r + 1'b1;
          state_r <= S_DRD;
        end
        S_SRD: begin
          if (i_r >= nbits_r) state_r <= S_OUT;
          else begin
            p_r <= '0; j_r <= '0; ok_r <= 1'b1; bad_r <= 1'b0;
            ta_r <= '0; tc_r <= '0; state_r <= S_SCHK;
          end
        end
        S_SCHK: begin
          // j_r odd phases sample the bit read at offset p_r
          if (!j_r[0]) begin
            j_r <= j_r + 1'b1;
          end else begin
            if (p_r < CW'(4)) begin
              if (bval != BIT_ONE) ok_r <= 1'b0;
            end else if (p_r < CW'(8)) begin
              ta_r <= {ta_r[2:0], bval == BIT_ONE};
              if (bval == BIT_INV) bad_r <= 1'b1;
            end else if (p_r < CW'(12)) begin
              tc_r <= {tc_r[2:0], bval == BIT_ONE};
              if (bval == BIT_INV) bad_r <= 1'b1;
            end else if (bval != BIT_ZERO) ok_r <= 1'b0;
            if (p_r == CW'(15)) begin
              if (ok_r && bval == BIT_ZERO) begin
                adr_r <= ta_r; cmd_r <= tc_r;
                if (bad_r || !kq[5]) begin
                  st_r <= ST_UNKNOWN; key_r <= '0;
                end else begin
                  st_r <= ST_KNOWN; key_r <= kq[4:0];
                end
              end
              i_r <= i_r + 1'b1; state_r <= S_SRD;
            end else begin
              p_r <= p_r + 1'b1; j_r <= j_r + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r <= {1'b0, cmd_r, adr_r, key_r, st_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule

>>> rtl/core/ird_checker.sv
// Port-level checker for the IR remote frame decoder, with its bind.
`include "ir_remote_frame_decoder_macros.svh"
module ird_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  `IRD_ASSERT_IMPL(a_status, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3)
  `IRD_ASSERT_IMPL(a_nokey, clk, rst_n, out_tvalid && out_tdata[1:0] != 2'd1, out_tdata[6:2] == 5'd0)
  `IRD_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `IRD_ASSERT_NEXT(a_busy, clk, rst_n, !in_tready && out_tvalid && !out_tready, !in_tready)
endmodule

bind ir_remote_frame_decoder ird_checker u_ird_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

>>> tb/ir_remote_frame_decoder_tb.sv
// Self-checking testbench for the IR remote frame decoder: random pulse-distance frames against a built-in predictor.
module ir_remote_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ird_pkg::*;

  localparam int Depth = 64;
  localparam int ShowLimit = 10;
  localparam int QuietLimit = 20000;
  localparam int SettleCycles = 4 * 128 + 40;
  localparam int ItemTarget = 800;
  localparam logic [CfgIdxW-1:0] CfgUnused = 4'd8;
  localparam iv_t IvMax = 27'h7FFFFFF;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] adr;
    logic [4:0] key;
    status_t    st;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [31:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [26:0] cfg_wdata;

  ir_remote_frame_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  iv_t win [8];
  iv_t prev_iv;
  bit collecting;
  int fcount;
  iv_t istore [Depth];
  bitcode_t frame_bits [Depth];
  int nbits;

  frame_res_t expected_frames[$];
  iv_t pending[$];

  int errors = 0;
  int results_seen = 0;
  int items_taken = 0;
  int items_pushed = 0;
  int quiet_cycles = 0;
  int in_wait = 0;
  int out_wait = 0;
  bit in_taken = 0;
  bit hold_input = 0;
  bit calm = 0;

  function automatic bit in_win(logic [27:0] v, iv_t lo, iv_t hi);
    return v > lo && v < hi;
  endfunction

  function automatic bitcode_t bit_at(int p);
    if (p >= nbits) return BIT_INV;
    return frame_bits[p];
  endfunction

  function automatic int key_lookup(logic [3:0] a, logic [3:0] c);
    case (a)
      4'd3: begin
        if (c == 4'd0) return 9;
        if (c <= 4'd9) return int'(c) - 1;
        if (c == 4'd15) return 14;
      end
      4'd5: begin
        case (c)
          4'd6: return 18;
          4'd7: return 19;
          4'd9: return 16;
          4'd8: return 17;
          default: ;
        endcase
      end
      4'd2: begin
        case (c)
          4'd15: return 10;
          4'd14: return 11;
          4'd13: return 12;
          4'd12: return 13;
          default: ;
        endcase
      end
      4'd15: if (c == 4'd4) return 15;
      default: ;
    endcase
    return -1;
  endfunction

  task automatic decode_frame();
    int i;
    int p;
    int k;
    logic [27:0] s;
    bitcode_t b;
    bit ok;
    bit bad;
    logic [3:0] a;
    logic [3:0] c;
    frame_res_t r;
    nbits = 0;
    i = 0;
    while (i < fcount) begin
      s = istore[i];
      if (in_win(s, win[REG_ONE_LOW], win[REG_ONE_HIGH])) b = BIT_ONE;
      else if (in_win(s, win[REG_ZERO_LOW], win[REG_ZERO_HIGH])) b = BIT_ZERO;
      else begin
        s = istore[i] + ((i + 1 < fcount) ? istore[i + 1] : 27'd0);
        if (in_win(s, win[REG_ONE_LOW], win[REG_ONE_HIGH])) begin
          b = BIT_ONE;
          i++;
        end else if (in_win(s, win[REG_ZERO_LOW], win[REG_ZERO_HIGH])) begin
          b = BIT_ZERO;
          i++;
        end else begin
          b = BIT_INV;
        end
      end
      frame_bits[nbits] = b;
      nbits++;
      i++;
    end
    r = '0;
    r.st = ST_NONE;
    for (p = 0; p < nbits; p++) begin
      if (frame_bits[p] != BIT_ONE) continue;
      ok = 1;
      for (int j = 0; j < 4; j++) begin
        if (bit_at(p + j) != BIT_ONE) ok = 0;
        if (bit_at(p + j + 12) != BIT_ZERO) ok = 0;
      end
      if (!ok) continue;
      bad = 0;
      a = '0;
      c = '0;
      for (int j = 0; j < 4; j++) begin
        if (bit_at(p + 4 + j) == BIT_INV) bad = 1;
        if (bit_at(p + 8 + j) == BIT_INV) bad = 1;
        a = {a[2:0], bit_at(p + 4 + j) == BIT_ONE};
        c = {c[2:0], bit_at(p + 8 + j) == BIT_ONE};
      end
      k = bad ? -1 : key_lookup(a, c);
      r.adr = a;
      r.cmd = c;
      if (k < 0) begin
        r.st = ST_UNKNOWN;
        r.key = '0;
      end else begin
        r.st = ST_KNOWN;
        r.key = 5'(k);
      end
    end
    expected_frames.push_back(r);
  endtask

  task automatic take_interval(iv_t x);
    logic [27:0] sum;
    iv_t kept;
    bit closing;
    sum = prev_iv + x;
    kept = x;
    closing = 0;
    if (fcount < Depth) istore[fcount] = x;
    else closing = 1;
    if (prev_iv != GapKept) begin
      if (in_win(x, win[REG_LEAD_LOW], win[REG_LEAD_HIGH]) ||
          in_win(sum, win[REG_GAP_LOW], win[REG_GAP_HIGH])) collecting = 1;
    end
    if (in_win(x, win[REG_GAP_LOW], win[REG_GAP_HIGH]) ||
        in_win(sum, win[REG_GAP_LOW], win[REG_GAP_HIGH])) begin
      kept = GapKept;
      closing = 1;
    end
    if (collecting && fcount < Depth) fcount++;
    prev_iv = kept;
    if (closing) begin
      decode_frame();
      fcount = 0;
      collecting = 0;
    end
  endtask

  task automatic note_mismatch(string what, int exp_v, int got_v);
    errors++;
    if (errors <= ShowLimit)
      $display("frame result %0d: %s expected %0d got %0d", results_seen, what, exp_v, got_v);
  endtask

  // Transfers are taken and checked at the rising edge.
  always @(posedge clk) begin
    frame_res_t e;
    frame_res_t g;
    if (rst_n) begin
      quiet_cycles++;
      if (in_tvalid && in_tready) begin
        take_interval(in_tdata[26:0]);
        in_taken = 1;
        items_taken++;
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        g = out_tdata[14:0];
        if (expected_frames.size() == 0) begin
          note_mismatch("unexpected transfer, status", -1, int'(g.st));
        end else begin
          e = expected_frames.pop_front();
          if (g.st != e.st) note_mismatch("status", e.st, g.st);
          if (g.key != e.key) note_mismatch("key_code", e.key, g.key);
          if (g.adr != e.adr) note_mismatch("frame_address", e.adr, g.adr);
          if (g.cmd != e.cmd) note_mismatch("frame_command", e.cmd, g.cmd);
        end
        results_seen++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("ir_remote_frame_decoder: mismatch");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken || !in_tvalid) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
          in_wait = $urandom_range(1, 10) - 1;
          in_tvalid <= 1'b0;
        end else if (!hold_input && pending.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, pending.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      in_taken = 0;
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_wait = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_iv(iv_t v);
    pending.push_back(v);
    items_pushed++;
  endtask

  function automatic iv_t mid(reg_idx_t lo, reg_idx_t hi);
    return iv_t'((28'(win[lo]) + 28'(win[hi])) / 2);
  endfunction

  task automatic push_noise();
    case ($urandom_range(0, 3))
      0: push_iv(iv_t'($urandom));
      1: push_iv(iv_t'($urandom_range(0, 2000)));
      2: push_iv(iv_t'($urandom_range(0, 500000)));
      default: push_iv($urandom_range(0, 1) ? IvMax : 27'd0);
    endcase
  endtask

  task automatic push_bit(bitcode_t b);
    iv_t v;
    iv_t part;
    case (b)
      BIT_ONE: v = mid(REG_ONE_LOW, REG_ONE_HIGH);
      BIT_ZERO: v = mid(REG_ZERO_LOW, REG_ZERO_HIGH);
      default: v = win[REG_ZERO_LOW] / 2;
    endcase
    if (b != BIT_INV && $urandom_range(0, 4) == 0) begin
      part = v / 3;
      push_iv(part);
      push_iv(v - part);
    end else begin
      push_iv(v);
    end
  endtask

  task automatic push_nibble(logic [3:0] n, int bad_pos);
    for (int j = 3; j >= 0; j--)
      push_bit((3 - j) == bad_pos ? BIT_INV : (n[j] ? BIT_ONE : BIT_ZERO));
  endtask

  // One frame: separator, lead, optional filler, 1111, address, command, 0000, optional trailing bits, gap.
  task automatic push_frame(logic [3:0] a, logic [3:0] c, bit broken, bit overflow);
    iv_t g;
    iv_t part;
    int bad_a;
    int bad_c;
    bad_a = broken && $urandom_range(0, 1) ? $urandom_range(0, 3) : -1;
    bad_c = broken && bad_a < 0 ? $urandom_range(0, 3) : -1;
    push_iv(win[REG_GAP_HIGH]);
    push_iv(mid(REG_LEAD_LOW, REG_LEAD_HIGH));
    if (overflow) begin
      repeat (Depth + $urandom_range(2, 8)) push_bit($urandom_range(0, 1) ? BIT_ONE : BIT_ZERO);
    end
    repeat ($urandom_range(0, 3)) push_bit($urandom_range(0, 1) ? BIT_ONE : BIT_ZERO);
    push_nibble(4'hF, -1);
    push_nibble(a, bad_a);
    push_nibble(c, bad_c);
    push_nibble(4'h0, -1);
    repeat ($urandom_range(0, 2)) push_bit($urandom_range(0, 1) ? BIT_ONE : BIT_ZERO);
    g = mid(REG_GAP_LOW, REG_GAP_HIGH);
    if ($urandom_range(0, 3) == 0) begin
      part = g / 2;
      push_iv(part);
      push_iv(g - part);
    end else begin
      push_iv(g);
    end
  endtask

  task automatic push_random_frame();
    logic [3:0] a;
    logic [3:0] c;
    case ($urandom_range(0, 4))
      0: a = 4'd3;
      1: a = 4'd5;
      2: a = 4'd2;
      3: a = 4'd15;
      default: a = 4'($urandom);
    endcase
    c = (a == 4'd15 && $urandom_range(0, 1)) ? 4'd4 : 4'($urandom);
    if ($urandom_range(0, 5) == 0) push_noise();
    push_frame(a, c, $urandom_range(0, 7) == 0, $urandom_range(0, 11) == 0);
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_windows(iv_t ll, iv_t lh, iv_t gl, iv_t gh,
                             iv_t ol, iv_t oh, iv_t zl, iv_t zh);
    iv_t vals [8];
    vals = '{ll, lh, gl, gh, ol, oh, zl, zh};
    for (int r = 0; r < 8; r++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CfgIdxW'(reg_idx_t'(r));
      cfg_wdata <= vals[r];
      win[r] = vals[r];
    end
    @(negedge clk);
    cfg_index <= CfgUnused + CfgIdxW'($urandom_range(0, 7));
    cfg_wdata <= 27'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int frames_sent;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    win = '{27'd400000, 27'd410000, 27'd420000, 27'd430000,
            27'd123000, 27'd127000, 27'd73000, 27'd77000};
    prev_iv = '0;
    collecting = 0;
    fcount = 0;
    frames_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, a known key, a broken nibble, a full buffer.
    push_iv(27'd0);
    push_iv(IvMax);
    push_frame(4'd3, 4'd0, 0, 0);
    push_frame(4'd15, 4'd4, 1, 0);
    push_frame(4'd9, 4'd9, 0, 1);
    frames_sent += 3;
    repeat (6) begin
      push_random_frame();
      frames_sent++;
    end
    drain();

    set_windows(27'd200000, 27'd205000, 27'd210000, 27'd215000,
                27'd61500, 27'd63500, 27'd36500, 27'd38500);
    repeat (12) begin
      push_random_frame();
      frames_sent++;
      if ($urandom_range(0, 2) == 0) push_noise();
    end
    while (pending.size() > 100) @(posedge clk);
    hold_input = 1;
    while (in_tvalid || expected_frames.size() != 0) @(posedge clk);
    hold_input = 0;
    drain();

    set_windows('0, '0, '0, '0, '0, '0, '0, '0);
    repeat (20) push_noise();
    drain();

    set_windows('0, IvMax, '0, IvMax, '0, '0, IvMax, IvMax);
    repeat (30) push_noise();
    drain();

    set_windows(27'd400000, 27'd410000, 27'd420000, 27'd430000,
                27'd123000, 27'd127000, 27'd73000, 27'd77000);
    while (items_pushed < ItemTarget) begin
      push_random_frame();
      frames_sent++;
      if ($urandom_range(0, 3) == 0) push_noise();
    end
    while (pending.size() > 150) @(posedge clk);
    calm = 1;
    drain();

    $display("Covered %0d intervals in %0d frames over five window settings;",
             items_taken, frames_sent);
    $display("%0d frame results were checked, %0d field errors.", results_seen, errors);
    if (errors == 0) begin
      $display("ir_remote_frame_decoder: match");
    end else begin
      $display("ir_remote_frame_decoder: mismatch");
    end
    $finish;
  end
endmodule

>>> ir_remote_frame_decoder.f
+incdir+rtl/core
rtl/core/ird_pkg.sv
rtl/core/ir_remote_frame_decoder.sv
rtl/core/ird_checker.sv
tb/ir_remote_frame_decoder_tb.sv
